@@ hw/rtl/pff_pkg.sv @@
// Shared constants and types for the two-objective Pareto front filter.
`default_nettype none
package pff_pkg;

    localparam int MAX_POINTS  = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int FIELD_W     = 32;
    localparam int IDX_OUT_W   = 6;
    localparam int S_TDATA_W   = 2 * FIELD_W;
    localparam int M_TDATA_W   = 8;
    localparam int M_TUSER_W   = 2;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOADI = 5'b00010,
        S_GETI  = 5'b00100,
        S_SWEEP = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

endpackage
`default_nettype wire

@@ hw/rtl/pareto_front_filter_2d.sv @@
// Two-objective Pareto front filter: batch store, pairwise sweep, per-point result stream.
// Usage:
//   Slave stream: one point per transaction, tdata = {obj_second, obj_first},
//   tlast marks the final point of a batch. Points arrive one per cycle while
//   the block is loading; a point beyond MAX_POINTS is discarded and the batch
//   result carries points_dropped.
//   After the tlast transaction the block evaluates the batch and stops taking
//   points until the last result has been handed to the output register.
//   Master stream: one transaction per stored point, in load order; tdata
//   holds point_index, tuser holds {points_dropped, on_front}, tlast marks the
//   final point of the batch.
//   Evaluation: each stored point in turn takes a read of the point, reads of
//   all candidates, a pipeline drain and an emit, all paced by the single
//   read port of the point memory.
//   A stalled master holds its output register; the sweep of the next point
//   waits in the emit step until the register frees up.
//   Reset empties the batch and clears the overflow flag and output valid;
//   point memory contents are not cleared.
`default_nettype none
module pareto_front_filter_2d #(
    parameter int MAX_POINTS  = pff_pkg::MAX_POINTS,
    parameter int VALUE_WIDTH = pff_pkg::VALUE_WIDTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [31:0] obj_first, [63:32] obj_second
    input  wire logic [pff_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  wire logic                          s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [5:0] point_index, [7:6] zero
    output logic      [pff_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // [0] on_front, [1] points_dropped
    output logic      [pff_pkg::M_TUSER_W-1:0] m_axis_tuser,
    output logic                               m_axis_tlast
);

    localparam int CW   = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam int IW   = $clog2(MAX_POINTS);
    localparam int CNTW = $clog2(MAX_POINTS + 1);

    pff_pkg::t_state r_state, n_state;

    logic [CNTW-1:0] r_count, n_count;
    logic            r_ovf, n_ovf;
    logic [CNTW-1:0] r_n, n_n;
    logic [IW-1:0]   r_i, n_i;
    logic [CNTW-1:0] r_j, n_j;
    logic [IW-1:0]   r_jd, n_jd;
    logic            r_dv, n_dv;
    logic            r_keep, n_keep;
    logic [2*CW-1:0] r_pi, n_pi;

    logic                          r_m_valid, n_m_valid;
    logic [pff_pkg::IDX_OUT_W-1:0] r_m_idx, n_m_idx;
    logic                          r_m_front, n_m_front;
    logic                          r_m_drop, n_m_drop;
    logic                          r_m_last, n_m_last;

    logic            s_hs;
    logic            room;
    logic            we;
    logic [IW-1:0]   raddr;
    logic [2*CW-1:0] rdata;
    logic            out_free;
    logic            is_last_i;
    logic            dom;
    logic            dup;

    assign s_axis_tready = (r_state == pff_pkg::S_IDLE);
    assign s_hs          = s_axis_tvalid && s_axis_tready;
    assign room          = (r_count < CNTW'(MAX_POINTS));
    assign we            = s_hs && room;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign is_last_i     = ((CNTW'(r_i) + CNTW'(1)) == r_n);

    pff_ram #(
        .WIDTH(2 * CW),
        .DEPTH(MAX_POINTS)
    ) u_points (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_count[IW-1:0]),
        .i_wdata({s_axis_tdata[pff_pkg::FIELD_W +: CW], s_axis_tdata[CW-1:0]}),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_comb begin
        dom = ($signed(rdata[CW-1:0]) <= $signed(r_pi[CW-1:0])) &&
              ($signed(rdata[2*CW-1:CW]) <= $signed(r_pi[2*CW-1:CW])) &&
              (($signed(rdata[CW-1:0]) < $signed(r_pi[CW-1:0])) ||
               ($signed(rdata[2*CW-1:CW]) < $signed(r_pi[2*CW-1:CW])));
        dup = (r_jd < r_i) && (rdata == r_pi);
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_n       = r_n;
        n_i       = r_i;
        n_j       = r_j;
        n_jd      = r_jd;
        n_dv      = r_dv;
        n_keep    = r_keep;
        n_pi      = r_pi;
        n_m_valid = r_m_valid && !m_axis_tready;
        n_m_idx   = r_m_idx;
        n_m_front = r_m_front;
        n_m_drop  = r_m_drop;
        n_m_last  = r_m_last;
        raddr     = r_i;

        case (r_state)
            pff_pkg::S_IDLE: begin
                if (s_hs) begin
                    if (room) begin
                        n_count = r_count + CNTW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        n_n     = room ? (r_count + CNTW'(1)) : r_count;
                        n_i     = '0;
                        n_state = pff_pkg::S_LOADI;
                    end
                end
            end
            pff_pkg::S_LOADI: begin
                raddr   = r_i;
                n_state = pff_pkg::S_GETI;
            end
            pff_pkg::S_GETI: begin
                n_pi    = rdata;
                raddr   = '0;
                n_jd    = '0;
                n_dv    = 1'b1;
                n_j     = CNTW'(1);
                n_keep  = 1'b1;
                n_state = pff_pkg::S_SWEEP;
            end
            pff_pkg::S_SWEEP: begin
                raddr = r_j[IW-1:0];
                if (r_dv && (r_jd != r_i) && (dom || dup)) begin
                    n_keep = 1'b0;
                end
                if (!r_dv) begin
                    n_state = pff_pkg::S_EMIT;
                end else if (r_j < r_n) begin
                    n_jd = r_j[IW-1:0];
                    n_j  = r_j + CNTW'(1);
                end else begin
                    n_dv = 1'b0;
                end
            end
            pff_pkg::S_EMIT: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_idx   = pff_pkg::IDX_OUT_W'(r_i);
                    n_m_front = r_keep;
                    n_m_drop  = r_ovf;
                    n_m_last  = is_last_i;
                    if (is_last_i) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = pff_pkg::S_IDLE;
                    end else begin
                        n_i     = r_i + IW'(1);
                        n_state = pff_pkg::S_LOADI;
                    end
                end
            end
            default: begin
                n_state = pff_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pff_pkg::S_IDLE;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_m_valid <= 1'b0;
            r_dv      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_m_valid <= n_m_valid;
            r_dv      <= n_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_i       <= n_i;
        r_j       <= n_j;
        r_jd      <= n_jd;
        r_keep    <= n_keep;
        r_pi      <= n_pi;
        r_m_idx   <= n_m_idx;
        r_m_front <= n_m_front;
        r_m_drop  <= n_m_drop;
        r_m_last  <= n_m_last;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = pff_pkg::M_TDATA_W'(r_m_idx);
    assign m_axis_tuser  = {r_m_drop, r_m_front};
    assign m_axis_tlast  = r_m_last;

endmodule
`default_nettype wire

@@ hw/rtl/pff_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pff_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ hw/rtl/pff_checker.sv @@
// Port-level checks for the Pareto front filter, bound to the top level.
`default_nettype none
module pff_port_assert (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          s_axis_tvalid,
    input wire logic                          s_axis_tready,
    input wire logic                          s_axis_tlast,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [pff_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input wire logic [pff_pkg::M_TUSER_W-1:0] m_axis_tuser,
    input wire logic                          m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("output transaction changed while stalled");

    a_busy_mid_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken while batch results remain");

    a_eval_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input taken right after final point");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind pareto_front_filter_2d pff_port_assert u_pff_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
);
`default_nettype wire

@@ sim/pff_checker.sv @@
// Checker for the Pareto front filter: predicts per-point front verdicts and compares results.
module pff_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [pff_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                          i_s_tlast,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [pff_pkg::M_TDATA_W-1:0] i_m_tdata,
    input  logic [pff_pkg::M_TUSER_W-1:0] i_m_tuser,
    input  logic                          i_m_tlast,
    output int                            o_failures,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import pff_pkg::*;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] index;
        logic                 on_front;
        logic                 dropped;
        logic                 last;
    } front_verdict_t;

    front_verdict_t     verdict_q[$];
    logic signed [31:0] held_first[MAX_POINTS];
    logic signed [31:0] held_second[MAX_POINTS];
    int                 held_count = 0;
    bit                 spilled = 1'b0;

    // true when point a dominates point b
    function automatic bit dominates(int a, int b);
        return held_first[a] <= held_first[b] && held_second[a] <= held_second[b] &&
               (held_first[a] < held_first[b] || held_second[a] < held_second[b]);
    endfunction

    task automatic load_point(input logic [S_TDATA_W-1:0] data, input logic last);
        front_verdict_t v;
        bit             keep;
        if (held_count < MAX_POINTS) begin
            held_first[held_count]  = data[FIELD_W-1:0];
            held_second[held_count] = data[2*FIELD_W-1:FIELD_W];
            held_count++;
        end else begin
            spilled = 1'b1;
        end
        if (last) begin
            for (int i = 0; i < held_count; i++) begin
                keep = 1'b1;
                for (int j = 0; j < held_count; j++) begin
                    if (j == i)
                        continue;
                    if (dominates(j, i))
                        keep = 1'b0;
                    // exact duplicates: only the earliest copy survives
                    else if (j < i && held_first[j] == held_first[i] &&
                             held_second[j] == held_second[i])
                        keep = 1'b0;
                end
                v.index    = i[IDX_OUT_W-1:0];
                v.on_front = keep;
                v.dropped  = spilled;
                v.last     = (i == held_count - 1);
                verdict_q.push_back(v);
            end
            held_count = 0;
            spilled    = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        o_failures++;
        if (o_failures <= 40)
            $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    task automatic check_result();
        front_verdict_t v;
        if (verdict_q.size() == 0) begin
            report_mismatch("unexpected result transaction, index", i_m_tdata, -1);
            return;
        end
        v = verdict_q.pop_front();
        if (i_m_tdata !== {{(M_TDATA_W-IDX_OUT_W){1'b0}}, v.index})
            report_mismatch("point_index", i_m_tdata, v.index);
        if (i_m_tuser[0] !== v.on_front)
            report_mismatch("on_front", i_m_tuser[0], v.on_front);
        if (i_m_tuser[1] !== v.dropped)
            report_mismatch("points_dropped", i_m_tuser[1], v.dropped);
        if (i_m_tlast !== v.last)
            report_mismatch("last_of_run", i_m_tlast, v.last);
    endtask

    initial begin
        o_failures = 0;
        o_pending  = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            verdict_q.delete();
            held_count = 0;
            spilled    = 1'b0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                load_point(i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready)
                check_result();
        end
        o_pending = verdict_q.size();
    end

endmodule

@@ sim/tb_top.sv @@
// Testbench top for the Pareto front filter: reset, point batches, output stalls, verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pff_pkg::*;

    localparam int                 TARGET_ITEMS = 470;
    // far above the slowest legal run of this stimulus
    localparam int                 CYCLE_LIMIT  = 2_000_000;
    localparam logic signed [31:0] LOWEST       = 32'sh8000_0000;
    localparam logic signed [31:0] HIGHEST      = 32'sh7fff_ffff;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;
    logic                 m_axis_tlast;

    int failures;
    int pending;
    int cycles = 0;
    int burst_left = 0;
    int points_sent = 0;

    always #6 i_clk = ~i_clk;

    pareto_front_filter_2d u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    pff_checker u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tlast  (s_axis_tlast),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .i_m_tuser  (m_axis_tuser),
        .i_m_tlast  (m_axis_tlast),
        .o_failures (failures),
        .o_pending  (pending)
    );

    // output backpressure: a stall mode is picked at random and held for a random duration
    int stall_mode = 0;
    int mode_left = 0;
    int stall_phase = 0;
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        stall_phase++;
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= $urandom_range(0, 1);
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= stall_phase[3];
        endcase
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // called at a falling edge; returns at a falling edge after the transaction
    task automatic send_point(input logic signed [31:0] first, input logic signed [31:0] second,
                              input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 :
                  $urandom_range(1, ($urandom_range(0, 7) == 0) ? 40 : 5);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {second, first};
        s_axis_tlast  <= last;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        @(negedge i_clk);
        burst_left--;
        points_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        burst_left = 0;
    endtask

    function automatic logic signed [31:0] pick_value(input int style);
        case (style)
            0: return $urandom;
            1: return $urandom_range(0, 6) - 3;
            2: begin
                case ($urandom_range(0, 6))
                    0: return LOWEST;
                    1: return LOWEST + 1;
                    2: return -1;
                    3: return 0;
                    4: return 1;
                    5: return HIGHEST - 1;
                    default: return HIGHEST;
                endcase
            end
            default: return pick_value($urandom_range(0, 2));
        endcase
    endfunction

    task automatic send_batch(input int size, input int style);
        for (int k = 0; k < size; k++)
            send_point(pick_value(style), pick_value(style), k == size - 1);
    endtask

    initial begin
        int size;
        int roll;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // single point batch
        send_point(LOWEST, LOWEST, 1'b1);
        // extremes, ties in one objective, exact duplicates
        send_point(HIGHEST, HIGHEST, 1'b0);
        send_point(LOWEST, HIGHEST, 1'b0);
        send_point(HIGHEST, LOWEST, 1'b0);
        send_point(0, 0, 1'b0);
        send_point(0, 0, 1'b0);
        send_point(3, 7, 1'b0);
        send_point(3, 5, 1'b0);
        send_point(-1, 5, 1'b0);
        send_point(5, -1, 1'b0);
        send_point(HIGHEST, HIGHEST, 1'b1);
        send_point(7, 7, 1'b0);
        send_point(7, 7, 1'b1);
        drain_results();

        // store exactly full, then overflow with tlast on a dropped point
        send_batch(MAX_POINTS, 3);
        send_batch(MAX_POINTS + 2, 1);
        drain_results();

        while (points_sent < TARGET_ITEMS) begin
            roll = $urandom_range(0, 19);
            if (roll == 0)
                size = $urandom_range(MAX_POINTS - 4, MAX_POINTS + 6);
            else if (roll < 4)
                size = $urandom_range(9, 30);
            else
                size = $urandom_range(1, 8);
            send_batch(size, $urandom_range(0, 3));
            if ($urandom_range(0, 9) == 0)
                drain_results();
        end

        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (failures == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ pareto_front_filter_2d.f @@
hw/rtl/pff_pkg.sv
hw/rtl/pff_ram.sv
hw/rtl/pareto_front_filter_2d.sv
hw/rtl/pff_checker.sv
sim/pff_checker.sv
sim/tb_top.sv
